FILE: sv/mcr_pkg.sv
// Shared constants and codes for the midpoint circle rasterizer.
`default_nettype none
package mcr_pkg;

  localparam int COORD_BITS_DEF  = 12;
  localparam int RADIUS_BITS_DEF = 11;
  localparam int COLOR_BITS      = 8;
  localparam int CAND_COUNT      = 8;
  localparam int CAND_IDX_BITS   = $clog2(CAND_COUNT);
  localparam int CFG_IDX_BITS    = 1;

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;

endpackage
`default_nettype wire

FILE: sv/mcr_step.sv
// Circle state and the one-step midpoint update for each start or active tick.
`default_nettype none
module mcr_step #(
  parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         accept,
  input  wire logic                         opcode,
  input  wire logic [COORD_BITS-1:0]        center_x,
  input  wire logic [COORD_BITS-1:0]        center_y,
  input  wire logic [RADIUS_BITS-1:0]       radius,
  input  wire logic [mcr_pkg::COLOR_BITS-1:0] red,
  input  wire logic [mcr_pkg::COLOR_BITS-1:0] green,
  input  wire logic [mcr_pkg::COLOR_BITS-1:0] blue,
  output logic                              emits,
  output logic [COORD_BITS-1:0]             cx_next,
  output logic [COORD_BITS-1:0]             cy_next,
  output logic [RADIUS_BITS-1:0]            ox_next,
  output logic [RADIUS_BITS-1:0]            oy_next,
  output logic [mcr_pkg::COLOR_BITS-1:0]    red_next,
  output logic [mcr_pkg::COLOR_BITS-1:0]    green_next,
  output logic [mcr_pkg::COLOR_BITS-1:0]    blue_next,
  output logic                              done_next
);

  localparam int DW = RADIUS_BITS + 3;

  logic [COORD_BITS-1:0]          cx;
  logic [COORD_BITS-1:0]          cy;
  logic [RADIUS_BITS-1:0]         ox;
  logic [RADIUS_BITS-1:0]         oy;
  logic [DW-1:0]                  dterm;
  logic [mcr_pkg::COLOR_BITS-1:0] red_q;
  logic [mcr_pkg::COLOR_BITS-1:0] green_q;
  logic [mcr_pkg::COLOR_BITS-1:0] blue_q;
  logic                           active;

  logic [DW-1:0] dterm_next;
  logic          active_next;
  logic [DW-2:0] x_e;
  logic [DW-2:0] y_e;

  always_comb begin
    x_e         = {{(DW-1-RADIUS_BITS){1'b0}}, ox};
    y_e         = {{(DW-1-RADIUS_BITS){1'b0}}, oy};
    cx_next     = cx;
    cy_next     = cy;
    ox_next     = ox;
    oy_next     = oy;
    dterm_next  = dterm;
    red_next    = red_q;
    green_next  = green_q;
    blue_next   = blue_q;
    emits       = 1'b0;
    if (opcode == mcr_pkg::OP_START) begin
      emits      = 1'b1;
      cx_next    = center_x;
      cy_next    = center_y;
      ox_next    = '0;
      oy_next    = radius;
      red_next   = red;
      green_next = green;
      blue_next  = blue;
      dterm_next = DW'(1) - {{(DW-RADIUS_BITS){1'b0}}, radius};
    end else if (active) begin
      emits = 1'b1;
      if (dterm[DW-1]) begin
        dterm_next = dterm + {x_e, 1'b0} + DW'(3);
      end else begin
        dterm_next = dterm + {x_e - y_e, 1'b0} + DW'(5);
        oy_next    = oy - RADIUS_BITS'(1);
      end
      ox_next = ox + RADIUS_BITS'(1);
    end
    active_next = ox_next < oy_next;
    done_next   = !active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cx      <= '0;
      cy      <= '0;
      ox      <= '0;
      oy      <= '0;
      dterm   <= '0;
      red_q   <= '0;
      green_q <= '0;
      blue_q  <= '0;
      active  <= 1'b0;
    end else if (accept && emits) begin
      cx      <= cx_next;
      cy      <= cy_next;
      ox      <= ox_next;
      oy      <= oy_next;
      dterm   <= dterm_next;
      red_q   <= red_next;
      green_q <= green_next;
      blue_q  <= blue_next;
      active  <= active_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/mcr_emit.sv
// Snapshot register and serializer that sends eight clipped candidates per step.
`default_nettype none
module mcr_emit #(
  parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           load,
  output logic                                load_ready,
  input  wire logic [COORD_BITS-1:0]          cx_in,
  input  wire logic [COORD_BITS-1:0]          cy_in,
  input  wire logic [RADIUS_BITS-1:0]         ox_in,
  input  wire logic [RADIUS_BITS-1:0]         oy_in,
  input  wire logic [mcr_pkg::COLOR_BITS-1:0] red_in,
  input  wire logic [mcr_pkg::COLOR_BITS-1:0] green_in,
  input  wire logic [mcr_pkg::COLOR_BITS-1:0] blue_in,
  input  wire logic                           done_in,
  input  wire logic [COORD_BITS:0]            image_width,
  input  wire logic [COORD_BITS:0]            image_height,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                write_valid,
  output logic [COORD_BITS-1:0]               pixel_x,
  output logic [COORD_BITS-1:0]               pixel_y,
  output logic [mcr_pkg::COLOR_BITS-1:0]      out_red,
  output logic [mcr_pkg::COLOR_BITS-1:0]      out_green,
  output logic [mcr_pkg::COLOR_BITS-1:0]      out_blue,
  output logic                                last_of_step,
  output logic                                circle_done
);

  localparam int MAXB  = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
  localparam int SUM_W = MAXB + 2;
  localparam logic [mcr_pkg::CAND_IDX_BITS-1:0] LAST_IDX =
    mcr_pkg::CAND_IDX_BITS'(mcr_pkg::CAND_COUNT - 1);

  logic                               snap_valid;
  logic [COORD_BITS-1:0]              cx;
  logic [COORD_BITS-1:0]              cy;
  logic [RADIUS_BITS-1:0]             ox;
  logic [RADIUS_BITS-1:0]             oy;
  logic [mcr_pkg::COLOR_BITS-1:0]     red_s;
  logic [mcr_pkg::COLOR_BITS-1:0]     green_s;
  logic [mcr_pkg::COLOR_BITS-1:0]     blue_s;
  logic                               done_s;
  logic [mcr_pkg::CAND_IDX_BITS-1:0]  idx;

  logic                   out_load;
  logic                   snap_free;
  logic [RADIUS_BITS-1:0] a;
  logic [RADIUS_BITS-1:0] b;
  logic [SUM_W-1:0]       cx_e;
  logic [SUM_W-1:0]       cy_e;
  logic [SUM_W-1:0]       a_e;
  logic [SUM_W-1:0]       b_e;
  logic [SUM_W-1:0]       w_e;
  logic [SUM_W-1:0]       h_e;
  logic [SUM_W-1:0]       px;
  logic [SUM_W-1:0]       py;
  logic                   ok;

  assign out_load   = snap_valid && (!out_valid || out_ready);
  assign snap_free  = out_load && (idx == LAST_IDX);
  assign load_ready = !snap_valid || snap_free;

  always_comb begin
    a    = idx[2] ? oy : ox;
    b    = idx[2] ? ox : oy;
    cx_e = {{(SUM_W-COORD_BITS){1'b0}}, cx};
    cy_e = {{(SUM_W-COORD_BITS){1'b0}}, cy};
    a_e  = {{(SUM_W-RADIUS_BITS){1'b0}}, a};
    b_e  = {{(SUM_W-RADIUS_BITS){1'b0}}, b};
    w_e  = {{(SUM_W-COORD_BITS-1){1'b0}}, image_width};
    h_e  = {{(SUM_W-COORD_BITS-1){1'b0}}, image_height};
    px   = idx[0] ? cx_e - a_e : cx_e + a_e;
    py   = idx[1] ? cy_e - b_e : cy_e + b_e;
    ok   = (px[SUM_W-1:COORD_BITS] == '0) && (py[SUM_W-1:COORD_BITS] == '0) &&
           (px < w_e) && (py < h_e);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
      idx        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (load) begin
        snap_valid <= 1'b1;
        idx        <= '0;
      end else if (snap_free) begin
        snap_valid <= 1'b0;
        idx        <= '0;
      end else if (out_load) begin
        idx <= idx + mcr_pkg::CAND_IDX_BITS'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cx      <= cx_in;
      cy      <= cy_in;
      ox      <= ox_in;
      oy      <= oy_in;
      red_s   <= red_in;
      green_s <= green_in;
      blue_s  <= blue_in;
      done_s  <= done_in;
    end
    if (out_load) begin
      write_valid  <= ok;
      pixel_x      <= ok ? px[COORD_BITS-1:0] : '0;
      pixel_y      <= ok ? py[COORD_BITS-1:0] : '0;
      out_red      <= red_s;
      out_green    <= green_s;
      out_blue     <= blue_s;
      last_of_step <= (idx == LAST_IDX);
      circle_done  <= done_s;
    end
  end

endmodule
`default_nettype wire

FILE: sv/midpoint_circle_rasterizer.sv
// Top level of the midpoint circle rasterizer: config registers, step and emitter.
//
// Input channel (in_valid/in_ready): opcode start latches centre, radius and
// color and draws offset (0, radius); opcode tick advances one midpoint step.
// Each start, and each tick while a circle is in progress, yields eight
// candidate pixel beats on the output channel (out_valid/out_ready), the last
// flagged by last_of_step. A tick with no circle in progress is taken and
// yields nothing. Candidates outside image_width x image_height carry
// write_valid low and zero coordinates.
// The first beat of an item is registered in the snapshot register and then
// in the output register.
// Throughput: the output register moves one beat per cycle while out_ready is
// high; the next item is taken while the eighth beat is loaded, so items
// flow without gaps.
// Config channel (cfg_valid/cfg_ready) is always ready; write only while idle.
// Reset: no circle in progress, width 640, height 480, output channel empty.
// Stall: a low out_ready holds the output beat; once the snapshot register is
// also full, in_ready drops until the current item's last beat moves.
`default_nettype none
module midpoint_circle_rasterizer #(
  parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [mcr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [COORD_BITS:0]                cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               opcode,
  input  wire logic [COORD_BITS-1:0]              center_x,
  input  wire logic [COORD_BITS-1:0]              center_y,
  input  wire logic [RADIUS_BITS-1:0]             radius,
  input  wire logic [mcr_pkg::COLOR_BITS-1:0]     red,
  input  wire logic [mcr_pkg::COLOR_BITS-1:0]     green,
  input  wire logic [mcr_pkg::COLOR_BITS-1:0]     blue,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    write_valid,
  output logic [COORD_BITS-1:0]                   pixel_x,
  output logic [COORD_BITS-1:0]                   pixel_y,
  output logic [mcr_pkg::COLOR_BITS-1:0]          out_red,
  output logic [mcr_pkg::COLOR_BITS-1:0]          out_green,
  output logic [mcr_pkg::COLOR_BITS-1:0]          out_blue,
  output logic                                    last_of_step,
  output logic                                    circle_done
);

  logic [COORD_BITS:0] image_width;
  logic [COORD_BITS:0] image_height;

  logic                           accept;
  logic                           emits;
  logic [COORD_BITS-1:0]          cx_next;
  logic [COORD_BITS-1:0]          cy_next;
  logic [RADIUS_BITS-1:0]         ox_next;
  logic [RADIUS_BITS-1:0]         oy_next;
  logic [mcr_pkg::COLOR_BITS-1:0] red_next;
  logic [mcr_pkg::COLOR_BITS-1:0] green_next;
  logic [mcr_pkg::COLOR_BITS-1:0] blue_next;
  logic                           done_next;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= (COORD_BITS + 1)'(mcr_pkg::WIDTH_RESET);
      image_height <= (COORD_BITS + 1)'(mcr_pkg::HEIGHT_RESET);
    end else if (cfg_valid) begin
      case (cfg_index)
        mcr_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        mcr_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  mcr_step #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .opcode    (opcode),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius    (radius),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .emits     (emits),
    .cx_next   (cx_next),
    .cy_next   (cy_next),
    .ox_next   (ox_next),
    .oy_next   (oy_next),
    .red_next  (red_next),
    .green_next(green_next),
    .blue_next (blue_next),
    .done_next (done_next)
  );

  mcr_emit #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (accept && emits),
    .load_ready  (in_ready),
    .cx_in       (cx_next),
    .cy_in       (cy_next),
    .ox_in       (ox_next),
    .oy_in       (oy_next),
    .red_in      (red_next),
    .green_in    (green_next),
    .blue_in     (blue_next),
    .done_in     (done_next),
    .image_width (image_width),
    .image_height(image_height),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .write_valid (write_valid),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .last_of_step(last_of_step),
    .circle_done (circle_done)
  );

endmodule
`default_nettype wire
